/* rtl/core/msr_pkg.sv */
`default_nettype none

package msr_pkg;

    // Store depth default
    localparam int SYSEX_DEPTH_DEF = 64;

    // Status byte codes
    localparam logic [7:0] ST_REALTIME_MASK = 8'hF8;
    localparam logic [7:0] ST_SYSEX_START   = 8'hF0;
    localparam logic [7:0] ST_DATA_MAX      = 8'h7F;
    localparam logic [7:0] ST_SYSEX_END     = 8'hF7;
    localparam logic [7:0] BYTE_MASK        = 8'hFF;

    // Result kinds
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    // One result transaction from the sequencer to the output register
    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [7:0]  byte_c;
        logic [31:0] stamp;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/midi_sysex_reassembler_unit.sv */
// MIDI SysEx reassembler.
// Input channel (in_valid/in_ready): one packed event word plus timestamp per
// transaction. Output channel (out_valid/out_ready): one result per
// transaction, either a short message or one byte of a completed SysEx run;
// last marks the final result caused by an input word.
// Timing: a word is classified in the cycle after its accept edge, and a short
// or real-time message is then loaded into the output register; the next word
// is taken only once the sequencer is back in idle.
// A SysEx word is written to the store byte by byte (up to 4 bytes; the store
// RAM has one write port). A closing word then reads the store and streams the
// run, one byte per cycle while the receiver is ready, from the store's read port.
// Reset clears the sequencer, the open-message flag and the byte count; the
// store RAM is not cleared, since only written entries are ever read.
// When the receiver stalls, the output register holds its result and the
// sequencer waits in place; it still accepts a word while a finished result
// waits, as long as it is idle.
`default_nettype none

module midi_sysex_reassembler_unit
    import msr_pkg::*;
#(
    parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] event_word,
    input  wire logic [31:0] stamp_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             msg_kind,
    output logic [7:0]       byte_a,
    output logic [7:0]       byte_b,
    output logic [7:0]       byte_c,
    output logic [31:0]      stamp_out,
    output logic             last
);

    localparam int AW = $clog2(SYSEX_DEPTH);

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;

    msr_seq #(
        .SYSEX_DEPTH (SYSEX_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .event_word (event_word),
        .stamp_ms   (stamp_ms),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    msr_ram #(
        .WIDTH (8),
        .DEPTH (SYSEX_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: loads when empty or being drained
    always_comb
    begin
        res_ready      = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign msg_kind  = out_reg.kind;
    assign byte_a    = out_reg.byte_a;
    assign byte_b    = out_reg.byte_b;
    assign byte_c    = out_reg.byte_c;
    assign stamp_out = out_reg.stamp;
    assign last      = out_reg.last;

endmodule

`default_nettype wire

/* rtl/core/msr_ram.sv */
`default_nettype none

module msr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/msr_seq.sv */
`default_nettype none

module msr_seq
    import msr_pkg::*;
#(
    parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [31:0]                    event_word,
    input  wire logic [31:0]                    stamp_ms,
    // result channel to the output register
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output res_t                                res,
    // store port
    output logic                                ram_we,
    output logic [$clog2(SYSEX_DEPTH)-1:0]      ram_waddr,
    output logic [7:0]                          ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(SYSEX_DEPTH)-1:0]      ram_raddr,
    input  wire logic [7:0]                     ram_rdata
);

    localparam int AW = $clog2(SYSEX_DEPTH);
    localparam int CW = $clog2(SYSEX_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLASS = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_DRD   = 3'd3;
    localparam logic [2:0] S_DEMIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   word_reg, word_next;
    logic [31:0]   stamp_reg, stamp_next;
    logic          in_sysex_reg, in_sysex_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    bsel_reg, bsel_next;
    logic [CW-1:0] rd_reg, rd_next;

    logic [7:0]    status;
    logic [7:0]    cur_byte;
    logic          is_rt;
    logic          is_abort;
    logic          store_full;
    logic [CW-1:0] rd_plus;
    logic          run_last;

    // Decode of the held word
    always_comb
    begin
        status     = word_reg[7:0];
        cur_byte   = word_reg[{bsel_reg, 3'b000} +: 8];
        is_rt      = (status & ST_REALTIME_MASK) == ST_REALTIME_MASK;
        is_abort   = in_sysex_reg && (status > ST_DATA_MAX) && (status < ST_SYSEX_END);
        store_full = count_reg == CW'(SYSEX_DEPTH);
        rd_plus    = rd_reg + CW'(1);
        run_last   = rd_plus == count_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        word_next     = word_reg;
        stamp_next    = stamp_reg;
        in_sysex_next = in_sysex_reg;
        count_next    = count_reg;
        bsel_next     = bsel_reg;
        rd_next       = rd_reg;

        in_ready   = state_reg == S_IDLE;
        res_valid  = 1'b0;
        res.kind   = KIND_SHORT;
        res.byte_a = status;
        res.byte_b = 8'h00;
        res.byte_c = 8'h00;
        res.stamp  = stamp_reg;
        res.last   = 1'b1;

        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = cur_byte;
        ram_re    = 1'b0;
        ram_raddr = rd_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = event_word;
                    stamp_next = stamp_ms;
                    state_next = S_CLASS;
                end
            end

            S_CLASS:
            begin
                if (is_rt)
                begin
                    // real-time pass-through, SysEx state untouched
                    res_valid = 1'b1;
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if ((!in_sysex_reg || is_abort) && status != ST_SYSEX_START)
                begin
                    // short message, dropping any open message
                    res_valid  = 1'b1;
                    res.byte_b = word_reg[15:8];
                    res.byte_c = word_reg[23:16];
                    if (res_ready)
                    begin
                        in_sysex_next = 1'b0;
                        count_next    = '0;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    if (!in_sysex_reg || is_abort)
                    begin
                        count_next = '0;
                    end
                    in_sysex_next = 1'b1;
                    bsel_next     = 2'd0;
                    state_next    = S_STORE;
                end
            end

            S_STORE:
            begin
                // one byte per cycle, low byte first
                if (!store_full)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                if (cur_byte == ST_SYSEX_END)
                begin
                    in_sysex_next = 1'b0;
                    rd_next       = '0;
                    state_next    = S_DRD;
                end
                else if (bsel_reg == 2'd3)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    bsel_next = bsel_reg + 2'd1;
                end
            end

            S_DRD:
            begin
                ram_re     = 1'b1;
                state_next = S_DEMIT;
            end

            S_DEMIT:
            begin
                // read data holds while the output stalls
                res_valid  = 1'b1;
                res.kind   = KIND_SYSEX;
                res.byte_a = ram_rdata;
                res.last   = run_last;
                if (res_ready)
                begin
                    if (run_last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_next   = rd_plus;
                        ram_re    = 1'b1;
                        ram_raddr = rd_plus[AW-1:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_sysex_reg <= 1'b0;
            count_reg    <= '0;
            bsel_reg     <= 2'd0;
            rd_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            in_sysex_reg <= in_sysex_next;
            count_reg    <= count_next;
            bsel_reg     <= bsel_next;
            rd_reg       <= rd_next;
        end
    end

    // Held transaction payload
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        stamp_reg <= stamp_next;
    end

endmodule

`default_nettype wire

/* tb/sysex_result_checker.sv */
`default_nettype none

module sysex_result_checker
    import msr_pkg::*;
#(
    parameter int DEPTH = SYSEX_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [31:0] event_word,
    input  wire logic [31:0] stamp_ms,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        msg_kind,
    input  wire logic [7:0]  byte_a,
    input  wire logic [7:0]  byte_b,
    input  wire logic [7:0]  byte_c,
    input  wire logic [31:0] stamp_out,
    input  wire logic        last,
    output int               fail_count,
    output int               pending,
    output int               results_seen,
    output int               runs_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the reassembly state
    logic       msg_open;
    logic [7:0] msg_bytes [0:DEPTH-1];
    logic [6:0] msg_len;

    res_t expected_results[$];
    int   errors;
    int   n_results;
    int   n_runs;

    function automatic void push_result(logic kind, logic [7:0] a, logic [7:0] b,
                                        logic [7:0] c, logic [31:0] stamp,
                                        logic is_last);
        res_t r;
        r.kind   = kind;
        r.byte_a = a;
        r.byte_b = b;
        r.byte_c = c;
        r.stamp  = stamp;
        r.last   = is_last;
        expected_results.push_back(r);
    endfunction

    // Work out every result caused by one accepted event word
    function automatic void reassemble_word(logic [31:0] w, logic [31:0] stamp);
        logic [7:0] status;
        logic [7:0] data;
        logic       closed;
        status = w[7:0];
        data   = 8'h00;
        closed = 1'b0;

        // real-time passes straight through, even inside SysEx
        if ((status & ST_REALTIME_MASK) == ST_REALTIME_MASK)
        begin
            push_result(KIND_SHORT, status, 8'h00, 8'h00, stamp, 1'b1);
            return;
        end

        // a channel or system common status drops an open message
        if (msg_open && status > ST_DATA_MAX && status < ST_SYSEX_END)
        begin
            msg_open = 1'b0;
            msg_len  = '0;
        end

        if (!msg_open)
        begin
            if (status == ST_SYSEX_START)
            begin
                msg_open = 1'b1;
            end
            else
            begin
                push_result(KIND_SHORT, status, w[15:8], w[23:16], stamp, 1'b1);
                return;
            end
        end

        // store bytes low first, up to and including the end marker
        for (int k = 0; k < 4 && !closed; k++)
        begin
            data = w[8*k +: 8];
            if (int'(msg_len) < DEPTH)
            begin
                msg_bytes[msg_len] = data;
                msg_len = msg_len + 7'd1;
            end
            if (data == ST_SYSEX_END)
                closed = 1'b1;
        end

        if (closed)
        begin
            msg_open = 1'b0;
            for (int i = 0; i < int'(msg_len); i++)
                push_result(KIND_SYSEX, msg_bytes[i], 8'h00, 8'h00, stamp,
                            (i + 1 == int'(msg_len)));
            msg_len = '0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
        end
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            msg_open = 1'b0;
            msg_len  = '0;
            expected_results.delete();
            errors       = 0;
            n_results    = 0;
            n_runs       = 0;
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
            runs_seen    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                reassemble_word(event_word, stamp_ms);

            if (out_valid && out_ready)
            begin
                n_results++;
                if (msg_kind === KIND_SYSEX && last === 1'b1)
                    n_runs++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h %h %h %h %h %h",
                             $time, msg_kind, byte_a, byte_b, byte_c,
                             stamp_out, last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("msg_kind", 32'(want.kind), 32'(msg_kind));
                    check_field("byte_a", 32'(want.byte_a), 32'(byte_a));
                    check_field("byte_b", 32'(want.byte_b), 32'(byte_b));
                    check_field("byte_c", 32'(want.byte_c), 32'(byte_c));
                    check_field("stamp_out", want.stamp, stamp_out);
                    check_field("last", 32'(want.last), 32'(last));
                end
            end

            fail_count   <= errors;
            pending      <= expected_results.size();
            results_seen <= n_results;
            runs_seen    <= n_runs;
        end
    end

endmodule

`default_nettype wire

/* tb/midi_sysex_reassembler_unit_test.sv */
`default_nettype none

module midi_sysex_reassembler_unit_test;

    import msr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_WORDS   = 370;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [31:0] event_word = '0;
    logic [31:0] stamp_ms   = '0;
    logic        out_ready  = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic        msg_kind;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic [31:0] stamp_out;
    logic        last;

    int fail_count;
    int pending;
    int results_seen;
    int runs_seen;
    int words_sent = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;

    midi_sysex_reassembler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .event_word(event_word),
        .stamp_ms  (stamp_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .msg_kind  (msg_kind),
        .byte_a    (byte_a),
        .byte_b    (byte_b),
        .byte_c    (byte_c),
        .stamp_out (stamp_out),
        .last      (last)
    );

    sysex_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .event_word  (event_word),
        .stamp_ms    (stamp_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .msg_kind    (msg_kind),
        .byte_a      (byte_a),
        .byte_b      (byte_b),
        .byte_c      (byte_c),
        .stamp_out   (stamp_out),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen),
        .runs_seen   (runs_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Byte for an upper slot of a SysEx word: never the end marker
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 127));
        b = 8'($urandom_range(8'h80, 8'hFF));
        if (b == ST_SYSEX_END)
            b = 8'hF6;
        return b;
    endfunction

    function automatic logic [31:0] rand_stamp();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] w, input logic [31:0] s);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        event_word <= w;
        stamp_ms   <= s;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    task automatic send_realtime();
        logic [31:0] w;
        w       = $urandom;
        w[7:0]  = 8'($urandom_range(8'hF8, 8'hFF));
        send_word(w, rand_stamp());
    endtask

    // One SysEx message: open, data words, then close or abort
    task automatic send_sysex(input bit long_msg, input bit aborted);
        int          n_data;
        int          pos;
        logic [31:0] w;
        n_data = long_msg ? $urandom_range(13, 18) : $urandom_range(0, 5);

        if ($urandom_range(0, 9) == 0)
            w = {24'($urandom_range(0, 32'hFF_FFFF)), 8'h00};
        else
            w = {body_byte(), body_byte(), body_byte(), 8'h00};
        w[7:0] = ST_SYSEX_START;
        send_word(w, rand_stamp());

        for (int k = 0; k < n_data; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_realtime();
            w = {body_byte(), body_byte(), body_byte(), 8'h00};
            w[7:0] = 8'($urandom_range(0, 127));
            send_word(w, rand_stamp());
        end

        if (aborted)
        begin
            w = $urandom;
            w[7:0] = 8'($urandom_range(8'h80, 8'hF6));
            send_word(w, rand_stamp());
        end
        else
        begin
            pos = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
            begin
                if (k < pos)
                    w[8*k +: 8] = (k == 0) ? 8'($urandom_range(0, 127)) : body_byte();
                else if (k == pos)
                    w[8*k +: 8] = ST_SYSEX_END;
                else
                    w[8*k +: 8] = 8'($urandom_range(0, 255));
            end
            send_word(w, rand_stamp());
        end
    endtask

    // Receiver: ready stretches broken by random stalls
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = idle_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [31:0] w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and plain short messages
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'hA564_3C90, $urandom);
        send_word(32'h0000_00F8, $urandom);
        // lone end marker outside a message
        send_word(32'h1234_56F7, $urandom);
        // whole message in the start word
        send_word(32'hF77E_01F0, $urandom);
        // real-time inside a message, high bytes stored as data, close mid-word
        send_word(32'h3322_11F0, $urandom);
        send_word(32'h1234_56FA, $urandom);
        send_word(32'hFF80_7F00, $urandom);
        send_word(32'hAABB_F705, $urandom);
        // abort by channel status, by the top and bottom of the abort range
        send_word(32'h0403_02F0, $urandom);
        send_word(32'h0040_3C90, $urandom);
        send_word(32'h0001_02F0, $urandom);
        send_word(32'h0000_00F6, $urandom);
        send_word(32'h0001_02F0, $urandom);
        send_word(32'h0011_2280, $urandom);
        // start byte inside a message restarts it
        send_word(32'h1011_12F0, $urandom);
        send_word(32'h2021_22F0, $urandom);
        send_word(32'h0000_00F7, $urandom);

        // random traffic, mostly well-formed messages
        while (words_sent < TARGET_WORDS)
        begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    send_sysex($urandom_range(0, 9) == 0, 1'b0);
                5:
                    send_sysex(1'b0, 1'b1);
                6:
                begin
                    w = $urandom;
                    w[7:0] = 8'($urandom_range(8'h80, 8'hF6));
                    if (w[7:0] == ST_SYSEX_START)
                        w[7:0] = 8'hF1;
                    send_word(w, rand_stamp());
                end
                7:
                    send_realtime();
                default:
                    send_word($urandom, rand_stamp());
            endcase
        end

        // a channel message closes out anything left open
        send_word(32'h0000_4080, rand_stamp());
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d event words: short, real-time, open/close/abort and overflow",
                 words_sent);
        $display("checked %0d results, %0d completed SysEx runs", results_seen, runs_seen);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/msr_pkg.sv
rtl/core/msr_ram.sv
rtl/core/msr_seq.sv
rtl/core/midi_sysex_reassembler_unit.sv
tb/sysex_result_checker.sv
tb/midi_sysex_reassembler_unit_test.sv
